// File: hdl/pdga_pkg.sv
// shared types and constants of the poisson-disk acceptance grid
// used by every module of the block; depends on nothing else
package pdga_pkg;

  // fixed field widths
  localparam int COORD_W    = 16;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int CELLS_W    = 7;
  localparam int OUT_IDX_W  = 12;
  localparam int LIN_W      = 2 * CELLS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 4;

  // neighbourhood scan: nine cells, the own cell in the middle
  localparam int NUM_STEPS    = 9;
  localparam int CENTER_STEP  = 4;
  localparam int DRAIN_CYCLES = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN   = 3'd4;

  // configuration reset values
  localparam logic [COORD_W-1:0] RADIUS_RST      = 16'd256;
  localparam logic [COORD_W-1:0] AREA_WIDTH_RST  = 16'd16384;
  localparam logic [COORD_W-1:0] AREA_HEIGHT_RST = 16'd16384;
  localparam logic [CELLS_W-1:0] CELLS_RST       = 7'd64;

  typedef enum logic [1:0] {
    CMD_TEST   = 2'd0,
    CMD_SEED   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_OCCUPIED = 3'd1,
    ST_CLOSE    = 3'd2,
    ST_OUTSIDE  = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [COORD_W-1:0] cand_x;
    logic [COORD_W-1:0] cand_y;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic [2:0]           status;
    logic [OUT_IDX_W-1:0] cell_index;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic              load_item;
    logic              div_start;
    logic              locate;
    logic              scan_issue;
    logic [STEP_W-1:0] scan_k;
    logic              store;
    logic              clear_en;
    logic              load_out;
    status_t           out_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic outside;
    logic center_occ;
    logic too_close;
    logic clear_last;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hdl/poisson_disk_grid_acceptor.sv
// top level of the poisson-disk acceptance grid
// depends on pdga_pkg, pdga_ctrl and pdga_dp
//
// Input channel (in_valid/in_ready/in_data) takes one command per transaction:
// test and insert, seed insert, or clear grid. Every input transaction gives
// exactly one result transaction on out_valid/out_ready/out_data.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write only while the block is idle.
// From input transaction to result load, a stored test runs the bit-serial
// cell divide and its done flag, the cell locate, 9 grid reads of the 3x3
// neighbourhood through one memory read port, the drain of the distance
// stages, the store and the report; a seed skips the scan and the drain, and
// an unused command goes straight to the report. A clear sweeps the grid
// memory one entry per cycle. One item is worked at a time; in_ready is high
// only while idle. After reset the same clearing pass runs with in_ready low;
// config writes are taken during it.
// Results sit in an output register: while the receiver stalls the block
// still takes and works the next item, and holds that result until the
// register is free.
module poisson_disk_grid_acceptor #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pdga_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pdga_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pdga_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdga_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pdga_pkg::dp_cmd_t ctl_cmd;
  pdga_pkg::dp_sts_t ctl_sts;

  assign cfg_ready = 1'b1;

  // controller
  pdga_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .cmd        (ctl_cmd),
    .sts        (ctl_sts)
  );

  // datapath
  pdga_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl_cmd),
    .sts       (ctl_sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // memory writes, reads and item capture never overlap
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl_cmd.store, ctl_cmd.clear_en, ctl_cmd.scan_issue, ctl_cmd.load_item}))
    else $error("conflicting datapath commands");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.load_out |-> ctl_sts.out_free)
    else $error("result register overwritten");

endmodule

// File: hdl/pdga_div.sv
// two-lane restoring divider, one quotient bit per cycle, shared divisor
// depends on pdga_pkg
module pdga_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pdga_pkg::COORD_W-1:0]  divisor,
  input  logic [pdga_pkg::COORD_W-1:0]  dividend_a,
  input  logic [pdga_pkg::COORD_W-1:0]  dividend_b,
  output logic [pdga_pkg::COORD_W-1:0]  quo_a,
  output logic [pdga_pkg::COORD_W-1:0]  quo_b,
  output logic                          done
);

  localparam int W = pdga_pkg::COORD_W;

  logic                         busy;
  logic [$clog2(W)-1:0]         step_cnt;
  logic [W-1:0]                 rem_a;
  logic [W-1:0]                 rem_b;
  logic [W+1:0]                 trial_a;
  logic [W+1:0]                 trial_b;
  logic [W-1:0]                 rem_a_next;
  logic [W-1:0]                 rem_b_next;
  logic [W-1:0]                 quo_a_next;
  logic [W-1:0]                 quo_b_next;

  // trial subtraction, the extra top bit holds the borrow
  always_comb begin
    trial_a    = {1'b0, rem_a, quo_a[W-1]} - {2'b00, divisor};
    trial_b    = {1'b0, rem_b, quo_b[W-1]} - {2'b00, divisor};
    rem_a_next = trial_a[W+1] ? {rem_a[W-2:0], quo_a[W-1]} : trial_a[W-1:0];
    rem_b_next = trial_b[W+1] ? {rem_b[W-2:0], quo_b[W-1]} : trial_b[W-1:0];
    quo_a_next = {quo_a[W-2:0], ~trial_a[W+1]};
    quo_b_next = {quo_b[W-2:0], ~trial_b[W+1]};
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        if (step_cnt == ($clog2(W))'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step_cnt <= step_cnt + 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_a <= dividend_a;
      quo_b <= dividend_b;
      rem_a <= '0;
      rem_b <= '0;
    end else if (busy) begin
      quo_a <= quo_a_next;
      quo_b <= quo_b_next;
      rem_a <= rem_a_next;
      rem_b <= rem_b_next;
    end
  end

endmodule

// File: hdl/pdga_dp.sv
// datapath: configuration, cell location, grid memory, distance pipeline, result
// depends on pdga_pkg and pdga_div
module pdga_dp #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pdga_pkg::dp_cmd_t                cmd,
  output pdga_pkg::dp_sts_t                sts,
  input  pdga_pkg::in_item_t               in_data,
  input  logic                             cfg_we,
  input  logic [pdga_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdga_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pdga_pkg::out_item_t              out_data
);

  localparam int          IDX_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int          CW        = pdga_pkg::COORD_W;
  localparam int          NW        = pdga_pkg::CELLS_W;
  localparam int          LW        = pdga_pkg::LIN_W;
  localparam int          MEM_W     = 1 + 2 * CW;
  localparam logic [31:0] CELLS_LIM = 32'(MAX_CELLS);

  // configuration registers
  logic [CW-1:0] radius;
  logic [CW-1:0] area_width;
  logic [CW-1:0] area_height;
  logic [NW-1:0] cells_across;
  logic [NW-1:0] cells_down;

  // item and location registers
  pdga_pkg::cmd_code_t item_cmd;
  logic [CW-1:0]       item_x;
  logic [CW-1:0]       item_y;
  logic [LW-1:0]       idx_q;
  logic [NW-1:0]       row_q;
  logic [NW-1:0]       col_q;
  logic [pdga_pkg::SQ_W-1:0] r2;

  logic [CW-1:0] qx;
  logic [CW-1:0] qy;
  logic          div_done;

  // location logic
  logic [LW-1:0] lin_c;
  logic          grid_out;
  logic          area_out;
  logic          outside;

  // neighbour address logic
  logic [1:0]    dr;
  logic [1:0]    dc;
  logic          nb_center;
  logic [NW:0]   nr;
  logic [NW:0]   nc;
  logic [LW-1:0] nb_lin;
  logic          nb_ok;

  // grid memory
  logic [MEM_W-1:0] grid_mem [MAX_CELLS];
  logic [MEM_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [MEM_W-1:0] wr_data;
  logic [IDX_W-1:0] clr_cnt;
  logic             clear_last;

  // distance pipeline
  logic                      p1_valid;
  logic                      p1_center;
  logic                      p2_hit;
  logic                      p2_center;
  logic [CW-1:0]             sx;
  logic [CW-1:0]             sy;
  logic [CW-1:0]             dx;
  logic [CW-1:0]             dy;
  logic [pdga_pkg::SQ_W-1:0] a2;
  logic [pdga_pkg::SQ_W-1:0] b2;
  logic                      near;
  logic                      center_occ;
  logic                      too_close;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= pdga_pkg::RADIUS_RST;
      area_width   <= pdga_pkg::AREA_WIDTH_RST;
      area_height  <= pdga_pkg::AREA_HEIGHT_RST;
      cells_across <= pdga_pkg::CELLS_RST;
      cells_down   <= pdga_pkg::CELLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdga_pkg::REG_RADIUS:       radius       <= cfg_data;
        pdga_pkg::REG_AREA_WIDTH:   area_width   <= cfg_data;
        pdga_pkg::REG_AREA_HEIGHT:  area_height  <= cfg_data;
        pdga_pkg::REG_CELLS_ACROSS: cells_across <= cfg_data[NW-1:0];
        pdga_pkg::REG_CELLS_DOWN:   cells_down   <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd <= pdga_pkg::cmd_code_t'(in_data.command);
      item_x   <= in_data.cand_x;
      item_y   <= in_data.cand_y;
    end
  end

  // column and row quotients
  pdga_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .divisor    (radius),
    .dividend_a (in_data.cand_x),
    .dividend_b (in_data.cand_y),
    .quo_a      (qx),
    .quo_b      (qy),
    .done       (div_done)
  );

  // cell index and outside checks
  always_comb begin
    lin_c    = ({{NW{1'b0}}, qy[NW-1:0]} * {{NW{1'b0}}, cells_across})
             + {{NW{1'b0}}, qx[NW-1:0]};
    grid_out = (qx >= {{(CW-NW){1'b0}}, cells_across})
            || (qy >= {{(CW-NW){1'b0}}, cells_down})
            || (32'(lin_c) >= CELLS_LIM);
    area_out = (item_x >= area_width) || (item_y >= area_height);
    outside  = grid_out || ((item_cmd == pdga_pkg::CMD_TEST) && area_out);
  end

  always_ff @(posedge clk) begin
    if (cmd.locate) begin
      idx_q <= lin_c;
      row_q <= qy[NW-1:0];
      col_q <= qx[NW-1:0];
      r2    <= {{CW{1'b0}}, radius} * {{CW{1'b0}}, radius};
    end
  end

  // neighbour offsets, code 0 is minus one, 1 none, 2 plus one
  always_comb begin
    unique case (cmd.scan_k)
      4'd0:    begin dr = 2'd0; dc = 2'd0; end
      4'd1:    begin dr = 2'd0; dc = 2'd1; end
      4'd2:    begin dr = 2'd0; dc = 2'd2; end
      4'd3:    begin dr = 2'd1; dc = 2'd0; end
      4'd4:    begin dr = 2'd1; dc = 2'd1; end
      4'd5:    begin dr = 2'd1; dc = 2'd2; end
      4'd6:    begin dr = 2'd2; dc = 2'd0; end
      4'd7:    begin dr = 2'd2; dc = 2'd1; end
      4'd8:    begin dr = 2'd2; dc = 2'd2; end
      default: begin dr = 2'd1; dc = 2'd1; end
    endcase
    nb_center = (cmd.scan_k == (pdga_pkg::STEP_W)'(pdga_pkg::CENTER_STEP));
    // row zero minus one wraps to all ones and fails the bound check
    nr     = {1'b0, row_q} + {{(NW-1){1'b0}}, dr} - {{NW{1'b0}}, 1'b1};
    nc     = {1'b0, col_q} + {{(NW-1){1'b0}}, dc} - {{NW{1'b0}}, 1'b1};
    nb_lin = ({{NW{1'b0}}, nr[NW-1:0]} * {{NW{1'b0}}, cells_across})
           + {{NW{1'b0}}, nc[NW-1:0]};
    nb_ok  = (nr < {1'b0, cells_down}) && (nc < {1'b0, cells_across})
          && (32'(nb_lin) < CELLS_LIM);
  end

  // memory ports
  always_comb begin
    rd_addr = IDX_W'(nb_lin);
    wr_en   = cmd.store || cmd.clear_en;
    wr_addr = cmd.clear_en ? clr_cnt : IDX_W'(idx_q);
    wr_data = cmd.clear_en ? '0 : {1'b1, item_x, item_y};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    rd_data <= grid_mem[rd_addr];
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= clear_last ? '0 : clr_cnt + 1'b1;
    end
  end

  assign clear_last = (clr_cnt == IDX_W'(MAX_CELLS - 1));

  // distance stage: absolute differences squared
  always_comb begin
    sx   = rd_data[2*CW-1:CW];
    sy   = rd_data[CW-1:0];
    dx   = (sx >= item_x) ? sx - item_x : item_x - sx;
    dy   = (sy >= item_y) ? sy - item_y : item_y - sy;
    near = (a2 <= r2) && (b2 <= (r2 - a2));
  end

  always_ff @(posedge clk) begin
    a2 <= {{CW{1'b0}}, dx} * {{CW{1'b0}}, dx};
    b2 <= {{CW{1'b0}}, dy} * {{CW{1'b0}}, dy};
    p1_center <= nb_center;
    p2_center <= p1_center;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_hit   <= 1'b0;
    end else begin
      p1_valid <= cmd.scan_issue && nb_ok;
      p2_hit   <= p1_valid && rd_data[MEM_W-1];
    end
  end

  // scan verdict flags
  always_ff @(posedge clk) begin
    if (rst) begin
      center_occ <= 1'b0;
      too_close  <= 1'b0;
    end else if (cmd.locate) begin
      center_occ <= 1'b0;
      too_close  <= 1'b0;
    end else if (p2_hit) begin
      if (p2_center) begin
        center_occ <= 1'b1;
      end else if (near) begin
        too_close <= 1'b1;
      end
    end
  end

  // status back to the controller
  assign sts.div_done   = div_done;
  assign sts.outside    = outside;
  assign sts.clear_last = clear_last;
  assign sts.center_occ = center_occ;
  assign sts.too_close  = too_close;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.accepted <= (cmd.out_status == pdga_pkg::ST_STORED);
      out_data.status   <= cmd.out_status;
      if ((cmd.out_status == pdga_pkg::ST_STORED)
          || (cmd.out_status == pdga_pkg::ST_OCCUPIED)
          || (cmd.out_status == pdga_pkg::ST_CLOSE)) begin
        out_data.cell_index <= idx_q[pdga_pkg::OUT_IDX_W-1:0];
      end else begin
        out_data.cell_index <= '0;
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

// File: hdl/pdga_ctrl.sv
// controller state machine: sequences divide, locate, scan, store, clear, report
// depends on pdga_pkg
module pdga_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  output pdga_pkg::dp_cmd_t cmd,
  input  pdga_pkg::dp_sts_t sts
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_DIVIDE = 8'b00000100,
    S_LOCATE = 8'b00001000,
    S_SCAN   = 8'b00010000,
    S_DRAIN  = 8'b00100000,
    S_STORE  = 8'b01000000,
    S_REPORT = 8'b10000000
  } state_t;

  state_t                        state;
  state_t                        state_next;
  pdga_pkg::cmd_code_t           item_cmd;
  pdga_pkg::cmd_code_t           item_cmd_next;
  pdga_pkg::cmd_code_t           in_cmd;
  pdga_pkg::status_t             res_status;
  pdga_pkg::status_t             res_status_next;
  logic [pdga_pkg::STEP_W-1:0]   step_k;
  logic [pdga_pkg::STEP_W-1:0]   step_k_next;
  logic [1:0]                    drain_cnt;
  logic [1:0]                    drain_cnt_next;
  logic                          clear_report;
  logic                          clear_report_next;

  assign in_cmd = pdga_pkg::cmd_code_t'(in_command);

  // next state and datapath commands
  always_comb begin
    state_next        = state;
    item_cmd_next     = item_cmd;
    res_status_next   = res_status;
    step_k_next       = step_k;
    drain_cnt_next    = drain_cnt;
    clear_report_next = clear_report;
    in_ready          = 1'b0;
    cmd               = '0;
    cmd.scan_k        = step_k;
    cmd.out_status    = res_status;

    unique case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_last) begin
          clear_report_next = 1'b0;
          if (clear_report) begin
            res_status_next = pdga_pkg::ST_CLEARED;
            state_next      = S_REPORT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          item_cmd_next = in_cmd;
          unique case (in_cmd)
            pdga_pkg::CMD_TEST, pdga_pkg::CMD_SEED: begin
              cmd.div_start = 1'b1;
              state_next    = S_DIVIDE;
            end
            pdga_pkg::CMD_CLEAR: begin
              clear_report_next = 1'b1;
              state_next        = S_CLEAR;
            end
            pdga_pkg::CMD_UNUSED: begin
              res_status_next = pdga_pkg::ST_OUTSIDE;
              state_next      = S_REPORT;
            end
          endcase
        end
      end
      S_DIVIDE: begin
        if (sts.div_done) begin
          state_next = S_LOCATE;
        end
      end
      S_LOCATE: begin
        cmd.locate = 1'b1;
        priority if (sts.outside) begin
          res_status_next = pdga_pkg::ST_OUTSIDE;
          state_next      = S_REPORT;
        end else if (item_cmd == pdga_pkg::CMD_SEED) begin
          state_next = S_STORE;
        end else begin
          step_k_next = '0;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (step_k == (pdga_pkg::STEP_W)'(pdga_pkg::NUM_STEPS - 1)) begin
          drain_cnt_next = '0;
          state_next     = S_DRAIN;
        end else begin
          step_k_next = step_k + 1'b1;
        end
      end
      S_DRAIN: begin
        // wait for the last read to pass the distance stages
        if (drain_cnt == 2'(pdga_pkg::DRAIN_CYCLES - 1)) begin
          priority if (sts.center_occ) begin
            res_status_next = pdga_pkg::ST_OCCUPIED;
            state_next      = S_REPORT;
          end else if (sts.too_close) begin
            res_status_next = pdga_pkg::ST_CLOSE;
            state_next      = S_REPORT;
          end else begin
            state_next = S_STORE;
          end
        end else begin
          drain_cnt_next = drain_cnt + 1'b1;
        end
      end
      S_STORE: begin
        cmd.store       = 1'b1;
        res_status_next = pdga_pkg::ST_STORED;
        state_next      = S_REPORT;
      end
      S_REPORT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clear_report <= 1'b0;
      step_k       <= '0;
      drain_cnt    <= '0;
      item_cmd     <= pdga_pkg::CMD_TEST;
      res_status   <= pdga_pkg::ST_OUTSIDE;
    end else begin
      state        <= state_next;
      clear_report <= clear_report_next;
      step_k       <= step_k_next;
      drain_cnt    <= drain_cnt_next;
      item_cmd     <= item_cmd_next;
      res_status   <= res_status_next;
    end
  end

endmodule

// File: bench/poisson_disk_grid_acceptor_test.sv
// testbench for poisson_disk_grid_acceptor: directed and random candidates checked
// against a grid predictor in a scoreboard class; depends on pdga_pkg and the block
module poisson_disk_grid_acceptor_test;

  localparam int GRID_CELLS     = 4096;
  localparam int NUM_PHASES     = 12;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int PRINT_CAP      = 50;

  // grid predictor and pending result store
  class grid_scoreboard;
    int unsigned radius, area_w, area_h, cells_across, cells_down;
    bit occupied [GRID_CELLS];
    logic [pdga_pkg::COORD_W-1:0] spot_x [GRID_CELLS];
    logic [pdga_pkg::COORD_W-1:0] spot_y [GRID_CELLS];
    pdga_pkg::out_item_t due_verdicts [$];
    int errors, n_checked, n_stored, n_taken, n_close, n_outside, n_cleared;

    function new();
      radius       = pdga_pkg::RADIUS_RST;
      area_w       = pdga_pkg::AREA_WIDTH_RST;
      area_h       = pdga_pkg::AREA_HEIGHT_RST;
      cells_across = pdga_pkg::CELLS_RST;
      cells_down   = pdga_pkg::CELLS_RST;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    function void set_reg(logic [pdga_pkg::CFG_IDX_W-1:0] idx,
                          logic [pdga_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        pdga_pkg::REG_RADIUS:       radius = val;
        pdga_pkg::REG_AREA_WIDTH:   area_w = val;
        pdga_pkg::REG_AREA_HEIGHT:  area_h = val;
        pdga_pkg::REG_CELLS_ACROSS: cells_across = val[pdga_pkg::CELLS_W-1:0];
        pdga_pkg::REG_CELLS_DOWN:   cells_down = val[pdga_pkg::CELLS_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_verdicts.size();
    endfunction

    // squared distance to the point held in a cell against radius squared
    function bit within_radius(int unsigned ni, int unsigned x, int unsigned y);
      longint unsigned r2, dx, dy, a2, b2;
      r2 = longint'(radius) * longint'(radius);
      dx = (spot_x[ni] >= x) ? spot_x[ni] - x : x - spot_x[ni];
      dy = (spot_y[ni] >= y) ? spot_y[ni] - y : y - spot_y[ni];
      a2 = dx * dx;
      b2 = dy * dy;
      if (a2 > r2) return 1'b0;
      return b2 <= r2 - a2;
    endfunction

    // works out the verdict for one candidate and updates the grid
    function pdga_pkg::out_item_t grade_candidate(pdga_pkg::in_item_t it);
      pdga_pkg::out_item_t res;
      int unsigned x, y, col, row, idx, ni;
      int nr, nc;
      res.accepted   = 1'b0;
      res.status     = pdga_pkg::ST_OUTSIDE;
      res.cell_index = '0;
      x = it.cand_x;
      y = it.cand_y;
      if (it.command == pdga_pkg::CMD_CLEAR) begin
        foreach (occupied[i]) occupied[i] = 1'b0;
        res.status = pdga_pkg::ST_CLEARED;
        n_cleared++;
        return res;
      end
      if (it.command == pdga_pkg::CMD_UNUSED) begin
        n_outside++;
        return res;
      end
      // cell lookup, a zero radius saturates the quotient
      col = (radius == 0) ? 32'hFFFF_FFFF : x / radius;
      row = (radius == 0) ? 32'hFFFF_FFFF : y / radius;
      if (col >= cells_across || row >= cells_down) begin
        n_outside++;
        return res;
      end
      idx = row * cells_across + col;
      if (idx >= GRID_CELLS) begin
        n_outside++;
        return res;
      end
      if (it.command == pdga_pkg::CMD_TEST) begin
        if (x >= area_w || y >= area_h) begin
          n_outside++;
          return res;
        end
        res.cell_index = idx[pdga_pkg::OUT_IDX_W-1:0];
        if (occupied[idx]) begin
          res.status = pdga_pkg::ST_OCCUPIED;
          n_taken++;
          return res;
        end
        // eight neighbours, nothing wraps at the grid edges
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = int'(row) + dr;
            nc = int'(col) + dc;
            if ((dr == 0 && dc == 0) || nr < 0 || nc < 0) continue;
            if (nr >= int'(cells_down) || nc >= int'(cells_across)) continue;
            ni = nr * cells_across + nc;
            if (ni >= GRID_CELLS || !occupied[ni]) continue;
            if (within_radius(ni, x, y)) begin
              res.status = pdga_pkg::ST_CLOSE;
              n_close++;
              return res;
            end
          end
        end
      end
      // store, seeds land here without the area, occupancy and neighbour checks
      spot_x[idx]    = x;
      spot_y[idx]    = y;
      occupied[idx]  = 1'b1;
      res.accepted   = 1'b1;
      res.status     = pdga_pkg::ST_STORED;
      res.cell_index = idx[pdga_pkg::OUT_IDX_W-1:0];
      n_stored++;
      return res;
    endfunction

    function void note_candidate(pdga_pkg::in_item_t it);
      due_verdicts = {due_verdicts, grade_candidate(it)};
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      if (errors <= PRINT_CAP)
        $display("mismatch at result %0d: %s got %0d, expected %0d", n_checked, what, got, want);
    endtask

    task check_verdict(pdga_pkg::out_item_t got);
      pdga_pkg::out_item_t want;
      if (due_verdicts.size() == 0) begin
        report_mismatch("unrequested result, status", got.status, '0);
        return;
      end
      want = due_verdicts.pop_front();
      n_checked++;
      if (got.accepted !== want.accepted)
        report_mismatch("accepted", got.accepted, want.accepted);
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.cell_index !== want.cell_index)
        report_mismatch("cell_index", got.cell_index, want.cell_index);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  pdga_pkg::in_item_t in_data;
  pdga_pkg::out_item_t out_data;
  logic [pdga_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pdga_pkg::CFG_DATA_W-1:0] cfg_data;

  grid_scoreboard sb;
  int idle_cycles = 0;
  int settings_used = 0;
  bit no_gaps = 1'b0;
  int unsigned cur_radius, cur_width, cur_height;
  int unsigned last_x = 0, last_y = 0;

  poisson_disk_grid_acceptor #(.MAX_CELLS(GRID_CELLS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // idle lengths: mostly short, a few long, none in steady stretches
  function automatic int pick_gap();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // random candidate: uniform in the area, near the last point, or anywhere
  function automatic pdga_pkg::in_item_t make_candidate();
    pdga_pkg::in_item_t it;
    int unsigned roll, spread, span_x, span_y;
    int x, y;
    roll = $urandom_range(0, 99);
    if (roll < 78) it.command = pdga_pkg::CMD_TEST;
    else if (roll < 93) it.command = pdga_pkg::CMD_SEED;
    else if (roll < 96) it.command = pdga_pkg::CMD_UNUSED;
    else it.command = pdga_pkg::CMD_CLEAR;
    roll = $urandom_range(0, 99);
    spread = (cur_radius == 0) ? 256 : cur_radius;
    if (roll < 12) begin
      x = $urandom_range(0, 65535);
      y = $urandom_range(0, 65535);
    end else if (roll < 55) begin
      x = clamp_coord(int'(last_x) + int'($urandom_range(0, 3 * spread)) - int'(3 * spread / 2));
      y = clamp_coord(int'(last_y) + int'($urandom_range(0, 3 * spread)) - int'(3 * spread / 2));
    end else begin
      span_x = (cur_width == 0) ? 65536 : cur_width;
      span_y = (cur_height == 0) ? 65536 : cur_height;
      x = $urandom_range(0, span_x - 1);
      y = $urandom_range(0, span_y - 1);
    end
    it.cand_x = x[pdga_pkg::COORD_W-1:0];
    it.cand_y = y[pdga_pkg::COORD_W-1:0];
    last_x = it.cand_x;
    last_y = it.cand_y;
    return it;
  endfunction

  // one input transaction, valid held until taken
  task automatic send_item(input pdga_pkg::in_item_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put(input pdga_pkg::cmd_code_t cmd, input int unsigned x,
                     input int unsigned y);
    pdga_pkg::in_item_t it;
    it.command = cmd;
    it.cand_x  = x[pdga_pkg::COORD_W-1:0];
    it.cand_y  = y[pdga_pkg::COORD_W-1:0];
    send_item(it);
  endtask

  // sender pauses until every pending result is out, then the block idles
  task automatic settle();
    in_valid <= 1'b0;
    // let the monitor note the last input transaction first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all five registers back to back
  task automatic write_regs(input int unsigned r, input int unsigned w, input int unsigned h,
                            input int unsigned ca, input int unsigned cd);
    logic [pdga_pkg::CFG_IDX_W-1:0] regs [5];
    logic [pdga_pkg::CFG_DATA_W-1:0] vals [5];
    regs = '{pdga_pkg::REG_RADIUS, pdga_pkg::REG_AREA_WIDTH, pdga_pkg::REG_AREA_HEIGHT,
             pdga_pkg::REG_CELLS_ACROSS, pdga_pkg::REG_CELLS_DOWN};
    vals = '{r[15:0], w[15:0], h[15:0], ca[15:0], cd[15:0]};
    cur_radius = r;
    cur_width  = w;
    cur_height = h;
    settings_used++;
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // transaction monitor: config, input and result handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_candidate(in_data);
      if (out_valid && out_ready) sb.check_verdict(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls
  initial begin
    int g;
    out_ready <= 1'b0;
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // main sequence
  initial begin
    int unsigned r, w, h, ca, cd, count;
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: default grid, 64 x 64 cells of 256
    write_regs(pdga_pkg::RADIUS_RST, pdga_pkg::AREA_WIDTH_RST, pdga_pkg::AREA_HEIGHT_RST,
               pdga_pkg::CELLS_RST, pdga_pkg::CELLS_RST);
    put(pdga_pkg::CMD_TEST, 0, 0);
    put(pdga_pkg::CMD_TEST, 0, 0);
    put(pdga_pkg::CMD_TEST, 300, 300);
    put(pdga_pkg::CMD_TEST, 600, 100);
    put(pdga_pkg::CMD_SEED, 10, 10);
    put(pdga_pkg::CMD_TEST, 16383, 16383);
    put(pdga_pkg::CMD_TEST, 16384, 0);
    put(pdga_pkg::CMD_TEST, 65535, 65535);
    put(pdga_pkg::CMD_SEED, 65535, 65535);
    put(pdga_pkg::CMD_UNUSED, 1234, 5678);
    put(pdga_pkg::CMD_TEST, 16383, 100);
    put(pdga_pkg::CMD_TEST, 5, 300);
    put(pdga_pkg::CMD_CLEAR, 0, 0);
    put(pdga_pkg::CMD_TEST, 0, 0);

    // directed: zero radius puts everything outside the grid
    settle();
    write_regs(0, 65535, 65535, 64, 64);
    put(pdga_pkg::CMD_TEST, 1, 1);
    put(pdga_pkg::CMD_SEED, 0, 0);

    // directed: widest radius, a single cell
    settle();
    write_regs(65535, 65535, 65535, 1, 1);
    put(pdga_pkg::CMD_TEST, 65534, 65534);
    put(pdga_pkg::CMD_TEST, 0, 0);
    put(pdga_pkg::CMD_SEED, 65535, 65535);

    // directed: small area, oversized grid reaching past the cell store
    settle();
    write_regs(256, 1000, 1000, 127, 127);
    put(pdga_pkg::CMD_TEST, 900, 900);
    put(pdga_pkg::CMD_TEST, 1000, 0);
    put(pdga_pkg::CMD_SEED, 1000, 0);
    put(pdga_pkg::CMD_SEED, 0, 10240);
    put(pdga_pkg::CMD_TEST, 700, 700);

    // random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: write_regs(1024, 16384, 16384, 17, 17);
        1: write_regs(65535, 65535, 65535, 1, 1);
        2: write_regs(1, 64, 64, 64, 64);
        3: write_regs(0, 65535, 65535, 64, 64);
        4: write_regs(700, 40000, 9000, 0, 127);
        5: write_regs(256, 65535, 65535, 127, 127);
        6: write_regs(2000, 0, 30000, 33, 16);
        default: begin
          r  = $urandom_range(200, 6000);
          w  = $urandom_range(r, 65535);
          h  = $urandom_range(r, 65535);
          ca = (w / r + 1 > 64) ? 64 : w / r + 1;
          cd = (h / r + 1 > 64) ? 64 : h / r + 1;
          if ($urandom_range(0, 1)) ca = $urandom_range(1, ca);
          write_regs(r, w, h, ca, cd);
        end
      endcase
      no_gaps = (ph % 4 == 2);
      if ($urandom_range(0, 1))
        put(pdga_pkg::CMD_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535));
      count = (ph == 3 || ph == 4) ? 40 : 155;
      repeat (count) send_item(make_candidate());
    end
    no_gaps = 1'b0;

    // drain and report
    settle();
    $display("run covered %0d candidates under %0d register settings with %0d grid clears",
             sb.n_checked, settings_used, sb.n_cleared);
    $display("outcomes: %0d stored, %0d cell taken, %0d too close, %0d outside; %0d mismatches",
             sb.n_stored, sb.n_taken, sb.n_close, sb.n_outside, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
